FILE: src/rpn_char_stream_evaluator_assert.svh
// Assertion macros for the evaluator
`ifndef RPN_CHAR_STREAM_EVALUATOR_ASSERT_SVH
`define RPN_CHAR_STREAM_EVALUATOR_ASSERT_SVH
// Implication checked on every rising clock edge, off during reset
`define RPN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define RPN_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: src/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and codes of the character-stream RPN evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MINUS    = 3'd1;
  localparam logic [2:0] ST_UNDER    = 3'd2;
  localparam logic [2:0] ST_DIVZERO  = 3'd3;
  localparam logic [2:0] ST_INVALID  = 3'd4;
  localparam logic [2:0] ST_NUMOVF   = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;
  localparam logic [2:0] ST_IGNORED  = 3'd7;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_POW   = 8'h5e;
  localparam logic [7:0] CH_MUL   = 8'h2a;
  localparam logic [7:0] CH_DIV   = 8'h2f;
  localparam logic [7:0] CH_MOD   = 8'h25;
  localparam logic [7:0] CH_ADD   = 8'h2b;
  localparam logic [7:0] CH_SUB   = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // ALU operation codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;
  localparam logic [2:0] OP_POW = 3'd5;

  typedef struct packed {
    logic        start;
    logic [2:0]  op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] result;
  } alu_rsp_t;
endpackage

FILE: src/rpn_stream_if.sv
// ----------------------------------------------------------------------------
// rpn_in_if / rpn_out_if
// Valid/ready channels of the evaluator.
// ----------------------------------------------------------------------------
interface rpn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_end;
  modport source (output valid, output char_code, output line_end, input ready);
  modport sink (input valid, input char_code, input line_end, output ready);
endinterface

interface rpn_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [63:0] top_value;
  logic [4:0]         stack_count;
  modport source (output valid, output status, output top_value, output stack_count,
                  input ready);
  modport sink (input valid, input status, input top_value, input stack_count,
                output ready);
endinterface

FILE: src/rpn_alu.sv
// ----------------------------------------------------------------------------
// rpn_alu
// Shared iterative unit: add/sub in one pass, multiply in one pass of a
// 32x32 partial product per cycle, divide/modulo one quotient bit per cycle,
// power by square-and-multiply over the shared multiplier.
// ----------------------------------------------------------------------------
module rpn_alu (
  input  logic              clk,
  input  logic              rst,
  input  rpn_pkg::alu_req_t req,
  output rpn_pkg::alu_rsp_t rsp
);
  localparam logic [3:0] A_IDLE = 4'd0;
  localparam logic [3:0] A_MUL  = 4'd1;
  localparam logic [3:0] A_DIV  = 4'd2;
  localparam logic [3:0] A_PSQ  = 4'd3;
  localparam logic [3:0] A_PMB  = 4'd4;
  localparam logic [3:0] A_DONE = 4'd5;
  localparam logic [3:0] A_PNX  = 4'd6;

  logic [3:0]  state;
  logic [2:0]  op;
  logic [63:0] opa, opb, res;
  logic [63:0] ma, mb, rem, quo;
  logic        na, nb;
  logic [6:0]  cnt;
  // multiplier
  logic [63:0] mx, my, macc;
  logic [1:0]  mstep;
  logic [3:0]  mret;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [64:0] rem_sh;
  logic [64:0] rem_sub;

  always_comb begin
    unique case (mstep)
      2'd0: begin pa = mx[31:0];  pb = my[31:0];  end
      2'd1: begin pa = mx[63:32]; pb = my[31:0];  end
      default: begin pa = mx[31:0]; pb = my[63:32]; end
    endcase
    pp = {32'd0, pa} * {32'd0, pb};
    rem_sh = {rem, ma[63]};
    rem_sub = rem_sh - {1'b0, mb};
  end

  assign rsp.busy = (state != A_IDLE);
  assign rsp.done = (state == A_DONE);
  assign rsp.result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            op <= req.op;
            opa <= req.a;
            opb <= req.b;
            na <= req.a[63];
            nb <= req.b[63];
            ma <= req.a[63] ? 64'd0 - req.a : req.a;
            mb <= req.b[63] ? 64'd0 - req.b : req.b;
            rem <= '0;
            quo <= '0;
            cnt <= 7'd0;
            unique case (req.op)
              rpn_pkg::OP_ADD: begin res <= req.a + req.b; state <= A_DONE; end
              rpn_pkg::OP_SUB: begin res <= req.a - req.b; state <= A_DONE; end
              rpn_pkg::OP_MUL: begin
                mx <= req.a; my <= req.b; mstep <= 2'd0; macc <= '0;
                mret <= A_DONE; state <= A_MUL;
              end
              rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: state <= A_DIV;
              rpn_pkg::OP_POW: begin
                if (req.b[63]) begin
                  if (req.a == 64'd1) res <= 64'd1;
                  else if (req.a == '1) res <= req.b[0] ? '1 : 64'd1;
                  else res <= '0;
                  state <= A_DONE;
                end else begin
                  res <= 64'd1;
                  cnt <= 7'd62;
                  state <= A_PSQ;
                end
              end
              default: begin res <= '0; state <= A_DONE; end
            endcase
          end
        end
        A_MUL: begin
          unique case (mstep)
            2'd0: begin macc <= pp; mstep <= 2'd1; end
            2'd1: begin macc <= macc + {pp[31:0], 32'd0}; mstep <= 2'd2; end
            default: begin
              res <= macc + {pp[31:0], 32'd0};
              state <= mret;
            end
          endcase
        end
        A_PSQ: begin
          // square step, multiplier result lands in res
          mx <= res; my <= res; mstep <= 2'd0; macc <= '0;
          mret <= A_PMB; state <= A_MUL;
        end
        A_PMB: begin
          if (opb[cnt[5:0]]) begin
            mx <= res; my <= opa; mstep <= 2'd0; macc <= '0;
            mret <= A_PNX; state <= A_MUL;
          end else if (cnt == 7'd0) begin
            state <= A_DONE;
          end else begin
            cnt <= cnt - 7'd1;
            state <= A_PSQ;
          end
        end
        A_PNX: begin
          if (cnt == 7'd0) state <= A_DONE;
          else begin
            cnt <= cnt - 7'd1;
            state <= A_PSQ;
          end
        end
        A_DIV: begin
          if (!rem_sub[64]) begin
            rem <= rem_sub[63:0]; quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh[63:0]; quo <= {quo[62:0], 1'b0};
          end
          ma <= {ma[62:0], 1'b0};
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) begin
            state <= A_DONE;
            if (op == rpn_pkg::OP_DIV) begin
              res <= (na != nb) ? 64'd0 - (!rem_sub[64] ? {quo[62:0], 1'b1} :
                     {quo[62:0], 1'b0}) : (!rem_sub[64] ? {quo[62:0], 1'b1} :
                     {quo[62:0], 1'b0});
            end else begin
              res <= na ? 64'd0 - (!rem_sub[64] ? rem_sub[63:0] : rem_sh[63:0]) :
                     (!rem_sub[64] ? rem_sub[63:0] : rem_sh[63:0]);
            end
          end
        end
        A_DONE: state <= A_IDLE;
        default: state <= A_IDLE;
      endcase
    end
  end
endmodule

FILE: src/rpn_char_stream_evaluator.sv
// A pending number is pushed before a space, t or operator is handled.
// + - * / % ^ go through the shared unit; / or % by zero does not.
// ^ walks 63 exponent bits, square then multiply.
// A held minus negates a following digit that does not end the line; else it subtracts.
// One char in flight: ready is low until its result beat leaves.
// Reset: synchronous, clears stack level and parse flags; stack words are not reset.
// ----------------------------------------------------------------------------
// rpn_char_stream_evaluator
// Character-stream RPN calculator over a 64-bit value stack.
// ----------------------------------------------------------------------------
`include "rpn_char_stream_evaluator_assert.svh"
module rpn_char_stream_evaluator #(
  parameter int STACK_DEPTH = 16
) (
  input logic clk,
  input logic rst,
  rpn_in_if.sink    in_ch,
  rpn_out_if.source out_ch
);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MINUS = 4'd1;
  localparam logic [3:0] S_CHAR  = 4'd3;
  localparam logic [3:0] S_BWAIT = 4'd4;
  localparam logic [3:0] S_FLUSH = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_RDW   = 4'd9;

  logic [3:0]  state, ret;
  logic [63:0] mem [STACK_DEPTH];
  logic [63:0] top, second;   // cached top two words
  logic [LW-1:0] level;
  logic [63:0] acc;
  logic        have, neg, mheld, failed;
  logic [7:0]  ch;
  logic        le;
  logic [2:0]  st;
  logic [2:0]  bop;
  logic [63:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic        ref_top;
  logic [2:0]  alu_op;
  logic [63:0] alu_a, alu_b;

  rpn_pkg::alu_req_t req;
  rpn_pkg::alu_rsp_t rsp;
  rpn_alu u_alu (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // start is sampled only while the unit is idle, so holding it through the wait is safe
  assign req = '{start: (state == S_BWAIT), op: alu_op, a: alu_a, b: alu_b};

  logic is_digit, is_op;
  logic [3:0] dval;
  logic [63:0] acc10;
  logic        dovf;
  logic [LW-1:0] lvm2;
  always_comb begin
    is_digit = (ch >= rpn_pkg::CH_ZERO) && (ch <= rpn_pkg::CH_NINE);
    is_op = (ch == rpn_pkg::CH_SPACE) || (ch == rpn_pkg::CH_T) ||
            (ch == rpn_pkg::CH_POW) || (ch == rpn_pkg::CH_MUL) ||
            (ch == rpn_pkg::CH_DIV) || (ch == rpn_pkg::CH_MOD) ||
            (ch == rpn_pkg::CH_ADD) || (ch == rpn_pkg::CH_SUB);
    dval = ch[3:0] - rpn_pkg::CH_ZERO[3:0];
    acc10 = {acc[60:0], 3'b000} + {acc[62:0], 1'b0} + {60'd0, dval};
    // acc*10+d > MAX  <=>  acc > (MAX-d)/10
    dovf = (acc > 64'd922337203685477580) ||
           ((acc == 64'd922337203685477580) && (dval > 4'd7));
    lvm2 = level - LW'(2);
    unique case (ch)
      rpn_pkg::CH_ADD: bop = rpn_pkg::OP_ADD;
      rpn_pkg::CH_SUB: bop = rpn_pkg::OP_SUB;
      rpn_pkg::CH_MUL: bop = rpn_pkg::OP_MUL;
      rpn_pkg::CH_DIV: bop = rpn_pkg::OP_DIV;
      rpn_pkg::CH_MOD: bop = rpn_pkg::OP_MOD;
      default:         bop = rpn_pkg::OP_POW;
    endcase
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.status = st;
  assign out_ch.top_value = (level == '0) ? 64'sd0 : $signed(top);
  assign out_ch.stack_count = 5'(level);

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      level <= '0;
      acc <= '0;
      have <= 1'b0;
      neg <= 1'b0;
      mheld <= 1'b0;
      failed <= 1'b0;
      ref_top <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            ch <= in_ch.char_code;
            le <= in_ch.line_end;
            if (failed) begin
              st <= rpn_pkg::ST_IGNORED;
              if (in_ch.line_end) begin
                failed <= 1'b0; acc <= '0; have <= 1'b0; neg <= 1'b0; mheld <= 1'b0;
              end
              state <= S_OUT;
            end else begin
              st <= rpn_pkg::ST_OK;
              state <= mheld ? S_MINUS : S_CHAR;
            end
          end
        end
        S_MINUS: begin
          mheld <= 1'b0;
          if (is_digit && !le) begin
            neg <= 1'b1; acc <= '0; have <= 1'b0; state <= S_CHAR;
          end else if (level < LW'(2)) begin
            st <= rpn_pkg::ST_UNDER; state <= S_FIN;
          end else begin
            alu_op <= rpn_pkg::OP_SUB;
            alu_a <= second; alu_b <= top;
            ret <= S_CHAR; state <= S_BWAIT;
          end
        end
        S_CHAR: begin
          if (is_digit) begin
            if (dovf) st <= rpn_pkg::ST_NUMOVF;
            else begin acc <= acc10; have <= 1'b1; end
            state <= S_FLUSH;
          end else if (!is_op) begin
            st <= rpn_pkg::ST_INVALID; state <= S_FIN;
          end else if (have) begin
            // push pending number first, then revisit this character
            have <= 1'b0; neg <= 1'b0; acc <= '0;
            if (level == LW'(STACK_DEPTH)) begin
              st <= rpn_pkg::ST_FULL; state <= S_FIN;
            end else begin
              mem[AW'(level)] <= neg ? 64'd0 - acc : acc;
              second <= top; top <= neg ? 64'd0 - acc : acc;
              level <= level + LW'(1);
            end
          end else if (ch == rpn_pkg::CH_SPACE) begin
            state <= S_FLUSH;
          end else if (ch == rpn_pkg::CH_T) begin
            if (level == '0) st <= rpn_pkg::ST_UNDER;
            else if (level == LW'(STACK_DEPTH)) st <= rpn_pkg::ST_FULL;
            else begin
              mem[AW'(level)] <= top; second <= top; level <= level + LW'(1);
            end
            state <= S_FLUSH;
          end else if (ch == rpn_pkg::CH_SUB && !le) begin
            mheld <= 1'b1; state <= S_FLUSH;
          end else if (level < LW'(2)) begin
            st <= rpn_pkg::ST_UNDER; state <= S_FIN;
          end else if ((bop == rpn_pkg::OP_DIV || bop == rpn_pkg::OP_MOD) &&
                       top == '0) begin
            // both operands go: reload top, then second
            st <= rpn_pkg::ST_DIVZERO; level <= lvm2; ref_top <= 1'b1;
            rd_addr <= AW'(level - LW'(3)); ret <= S_FIN; state <= S_RD;
          end else begin
            alu_op <= bop; alu_a <= second; alu_b <= top;
            ret <= S_FLUSH; state <= S_BWAIT;
          end
        end
        S_BWAIT: begin
          if (rsp.done) begin
            level <= level - LW'(1);
            mem[AW'(lvm2)] <= rsp.result;
            top <= rsp.result;
            rd_addr <= AW'(level - LW'(3));
            ref_top <= 1'b0;
            state <= S_RD;
          end
        end
        // read data is registered during S_RD and is ready in S_RDW
        S_RD: state <= S_RDW;
        S_RDW: begin
          if (ref_top) begin
            top <= rd_data;
            ref_top <= 1'b0;
            rd_addr <= AW'(level - LW'(2));
            state <= S_RD;
          end else begin
            second <= rd_data;
            state <= ret;
          end
        end
        S_FLUSH: begin
          if (st != rpn_pkg::ST_OK) state <= S_FIN;
          else if (le && have) begin
            have <= 1'b0; neg <= 1'b0; acc <= '0;
            if (level == LW'(STACK_DEPTH)) st <= rpn_pkg::ST_FULL;
            else begin
              mem[AW'(level)] <= neg ? 64'd0 - acc : acc;
              second <= top; top <= neg ? 64'd0 - acc : acc;
              level <= level + LW'(1);
            end
            state <= S_FIN;
          end else state <= S_FIN;
        end
        S_FIN: begin
          if (st != rpn_pkg::ST_OK || le) begin
            acc <= '0; have <= 1'b0; neg <= 1'b0; mheld <= 1'b0;
          end
          if (st != rpn_pkg::ST_OK) failed <= !le;
          else if (mheld) st <= rpn_pkg::ST_MINUS;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `RPN_ASSERT_IMP(a_ready_idle, clk, rst, in_ch.ready, !out_ch.valid,
                  "input ready while result beat pending")
  `RPN_ASSERT_IMP(a_level_max, clk, rst, 1'b1, level <= LW'(STACK_DEPTH),
                  "stack level above depth")
  `RPN_ASSERT_NXT(a_out_hold, clk, rst, out_ch.valid && !out_ch.ready,
                  out_ch.valid && $stable(out_ch.status), "result beat dropped")
  `RPN_ASSERT_IMP(a_alu_idle, clk, rst, in_ch.ready, !rsp.busy,
                  "shared unit busy while taking input")
endmodule
